// ===== hdl/pending_command_retry_table_top_defines.svh =====
// ---------------------------------------------------------------------------
// pending command retry table assertion macros
// concurrent assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef PENDING_COMMAND_RETRY_TABLE_TOP_DEFINES_SVH
`define PENDING_COMMAND_RETRY_TABLE_TOP_DEFINES_SVH

// generic clocked property, disabled while the active-low reset is asserted
`define PCRT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("pcrt assertion failed");

// a stalled valid stays up and its payload holds
`define PCRT_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, data) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(data))) \
        else $error("pcrt stalled payload changed");

`endif

// ===== hdl/pcrt_pkg.sv =====
// ---------------------------------------------------------------------------
// pcrt_pkg
// shared types and constants of the pending command retry table
// ---------------------------------------------------------------------------
package pcrt_pkg;

    localparam int unsigned RESET_TIMEOUT = 1000;
    localparam int unsigned RESET_RETRIES = 3;
    localparam int          APB_AW        = 3;
    localparam logic [3:0]  RESULT_CAP    = 4'd8;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_RETRIES = 1'b1;

    typedef enum logic [1:0] {
        OP_REG   = 2'd0,
        OP_ACK   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_REG    = 3'd1,
        KIND_EVICT  = 3'd2,
        KIND_FREED  = 3'd3,
        KIND_RETX   = 3'd4,
        KIND_GIVEUP = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PASS2,
        S_REGW,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [31:0] timeout_ms;
        logic [3:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic [31:0] device;
        logic [7:0]  channel;
        logic [15:0] sequence_no;
        logic [15:0] tag;
        logic [31:0] sent_time;
        logic [3:0]  retries;
    } t_entry;

    typedef struct packed {
        logic        last;
        t_kind       kind;
        logic [2:0]  slot;
        logic [31:0] device;
        logic [15:0] sequence_no;
        logic [15:0] tag;
        logic [3:0]  freed;
    } t_res;

endpackage

// ===== hdl/pcrt_ram.sv =====
// ---------------------------------------------------------------------------
// pcrt_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module pcrt_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pcrt_cfg.sv =====
// ---------------------------------------------------------------------------
// pcrt_cfg
// apb register file holding timeout and retry count
// ---------------------------------------------------------------------------
module pcrt_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [pcrt_pkg::APB_AW-1:0] i_paddr,
    input  logic [31:0]               i_pwdata,
    output logic [31:0]               o_prdata,
    output pcrt_pkg::t_cfg            o_cfg
);
    import pcrt_pkg::*;

    t_cfg r_cfg;
    logic w_wr;
    logic w_sel;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_sel = i_paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms  <= 32'(RESET_TIMEOUT);
            r_cfg.max_retries <= 4'(RESET_RETRIES);
        end else if (w_wr) begin
            if (w_sel == REG_TIMEOUT) begin
                r_cfg.timeout_ms <= i_pwdata;
            end else begin
                r_cfg.max_retries <= i_pwdata[3:0];
            end
        end
    end

    assign o_prdata = (w_sel == REG_RETRIES) ? {28'd0, r_cfg.max_retries}
                                             : r_cfg.timeout_ms;
    assign o_cfg    = r_cfg;

endmodule

// ===== hdl/pcrt_engine.sv =====
// ---------------------------------------------------------------------------
// pcrt_engine
// slot sequencer: one table entry per cycle, unless results stall, through a shared compare unit
// ---------------------------------------------------------------------------
module pcrt_engine #(
    parameter int  SLOTS = 8,
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int TW    = $clog2(SLOTS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pcrt_pkg::t_cfg i_cfg,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [111:0]   i_s_tdata,
    input  logic [1:0]     i_s_tuser,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output pcrt_pkg::t_res o_res
);
    import pcrt_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [SLOTS-1:0] r_used, n_used;
    t_op           r_op, n_op;
    logic [31:0]   r_dev, n_dev;
    logic [7:0]    r_ch, n_ch;
    logic [15:0]   r_seq, n_seq;
    logic [15:0]   r_tag, n_tag;
    logic [31:0]   r_now, n_now;
    logic [7:0]    r_mask, n_mask;
    logic          r_found, n_found;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [IW-1:0] r_min_idx, n_min_idx;
    t_entry        r_min, n_min;
    logic [TW-1:0] r_total, n_total;
    logic [3:0]    r_cnt, n_cnt;
    logic          r_pend_v, n_pend_v;
    t_res          r_pend, n_pend;
    logic          r_out_v, n_out_v;
    t_res          r_out, n_out;

    t_entry        w_rd;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;

    logic          w_used_i;
    logic [63:0]   w_mask_ext;
    logic          w_reach;
    logic [31:0]   w_age;
    logic          w_due;
    logic          w_dev_hit;
    logic          w_last_idx;
    logic [IW-1:0] w_reg_slot;
    logic          w_can_push;
    logic          e_v;
    t_res          e_res;
    logic          w_stall;

    pcrt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx),
        .o_rdata (w_rd)
    );

    assign w_used_i   = r_used[r_idx];
    assign w_mask_ext = 64'(r_mask);
    assign w_reach    = w_mask_ext[6'(r_idx)];
    assign w_age      = r_now - w_rd.sent_time;
    assign w_due      = w_used_i && (w_age >= i_cfg.timeout_ms);
    assign w_dev_hit  = w_used_i && (w_rd.device == r_dev);
    assign w_last_idx = (r_idx == LAST_IDX);
    assign w_reg_slot = r_found ? r_free_idx : r_min_idx;
    assign w_can_push = !r_out_v || i_m_tready;

    // result produced by the slot under the compare unit, or by the register write
    always_comb begin
        e_v   = 1'b0;
        e_res = '0;
        unique case (r_state)
            S_SCAN: begin
                unique case (r_op)
                    OP_ACK: begin
                        if (w_dev_hit && (w_rd.sequence_no == r_seq) && !r_found) begin
                            e_v = 1'b1;
                            e_res.kind = KIND_FREED;
                        end
                    end
                    OP_TICK: begin
                        if (w_due) begin
                            e_v = 1'b1;
                            e_res.kind = ((w_rd.retries != 4'd0) && w_reach) ? KIND_RETX
                                                                          : KIND_GIVEUP;
                        end
                    end
                    OP_REG, OP_CLEAR: ;
                endcase
                e_res.slot        = 3'(r_idx);
                e_res.device      = w_rd.device;
                e_res.sequence_no = w_rd.sequence_no;
                e_res.tag         = w_rd.tag;
            end
            S_PASS2: begin
                e_v               = w_dev_hit && (w_rd.channel == r_ch);
                e_res.kind        = KIND_FREED;
                e_res.slot        = 3'(r_idx);
                e_res.device      = w_rd.device;
                e_res.sequence_no = w_rd.sequence_no;
                e_res.tag         = w_rd.tag;
                e_res.freed       = 4'(r_total);
            end
            S_REGW: begin
                e_v        = 1'b1;
                e_res.slot = 3'(w_reg_slot);
                if (r_found) begin
                    e_res.kind        = KIND_REG;
                    e_res.device      = r_dev;
                    e_res.sequence_no = r_seq;
                    e_res.tag         = r_tag;
                end else begin
                    e_res.kind        = KIND_EVICT;
                    e_res.device      = r_min.device;
                    e_res.sequence_no = r_min.sequence_no;
                    e_res.tag         = r_min.tag;
                end
            end
            default: ;
        endcase
    end

    assign w_stall = e_v && (r_cnt != RESULT_CAP) && r_pend_v && !w_can_push;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_used     = r_used;
        n_op       = r_op;
        n_dev      = r_dev;
        n_ch       = r_ch;
        n_seq      = r_seq;
        n_tag      = r_tag;
        n_now      = r_now;
        n_mask     = r_mask;
        n_found    = r_found;
        n_free_idx = r_free_idx;
        n_min_idx  = r_min_idx;
        n_min      = r_min;
        n_total    = r_total;
        n_cnt      = r_cnt;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = r_out_v && !i_m_tready;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = w_rd;

        // queue a result: the previous one moves to the output register
        if (e_v && !w_stall && (r_cnt != RESULT_CAP)) begin
            if (r_pend_v) begin
                n_out   = r_pend;
                n_out_v = 1'b1;
            end
            n_pend   = e_res;
            n_pend_v = 1'b1;
            n_cnt    = r_cnt + 4'd1;
        end

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_s_tvalid) begin
                    n_op     = t_op'(i_s_tuser[1:0]);
                    n_dev    = i_s_tdata[31:0];
                    n_ch     = i_s_tdata[39:32];
                    n_seq    = i_s_tdata[55:40];
                    n_tag    = i_s_tdata[71:56];
                    n_now    = i_s_tdata[103:72];
                    n_mask   = i_s_tdata[111:104];
                    n_found  = 1'b0;
                    n_total  = '0;
                    n_cnt    = '0;
                    n_pend_v = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_stall) begin
                    unique case (r_op)
                        OP_REG: begin
                            if (!w_used_i && !r_found) begin
                                n_found    = 1'b1;
                                n_free_idx = r_idx;
                            end
                            if (w_used_i && ((r_idx == '0) ||
                                             (w_rd.sent_time < r_min.sent_time))) begin
                                n_min_idx = r_idx;
                                n_min     = w_rd;
                            end
                        end
                        OP_ACK: begin
                            if (e_v) begin
                                n_found       = 1'b1;
                                n_used[r_idx] = 1'b0;
                            end
                        end
                        OP_CLEAR: begin
                            if (w_dev_hit && (w_rd.channel == r_ch)) begin
                                n_total = r_total + TW'(1);
                            end
                        end
                        OP_TICK: begin
                            if (e_v) begin
                                if (e_res.kind == KIND_RETX) begin
                                    ram_we              = 1'b1;
                                    ram_wdata.retries   = w_rd.retries - 4'd1;
                                    ram_wdata.sent_time = r_now;
                                end else begin
                                    n_used[r_idx] = 1'b0;
                                end
                            end
                        end
                    endcase
                    if (w_last_idx) begin
                        n_idx = '0;
                        priority case (r_op)
                            OP_REG:   n_state = S_REGW;
                            OP_CLEAR: n_state = S_PASS2;
                            default:  n_state = S_FINISH;
                        endcase
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_PASS2: begin
                if (!w_stall) begin
                    if (e_v) begin
                        n_used[r_idx] = 1'b0;
                    end
                    if (w_last_idx) begin
                        n_state = S_FINISH;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_REGW: begin
                ram_we                = 1'b1;
                ram_waddr             = w_reg_slot;
                ram_wdata.device      = r_dev;
                ram_wdata.channel     = r_ch;
                ram_wdata.sequence_no = r_seq;
                ram_wdata.tag         = r_tag;
                ram_wdata.sent_time   = r_now;
                ram_wdata.retries     = i_cfg.max_retries;
                n_used[w_reg_slot]    = 1'b1;
                n_state               = S_FINISH;
            end
            S_FINISH: begin
                if (w_can_push) begin
                    if (r_pend_v) begin
                        n_out = r_pend;
                    end else begin
                        n_out = '0;
                    end
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_used   <= '0;
            r_found  <= 1'b0;
            r_total  <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_used   <= n_used;
            r_found  <= n_found;
            r_total  <= n_total;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_dev      <= n_dev;
        r_ch       <= n_ch;
        r_seq      <= n_seq;
        r_tag      <= n_tag;
        r_now      <= n_now;
        r_mask     <= n_mask;
        r_free_idx <= n_free_idx;
        r_min_idx  <= n_min_idx;
        r_min      <= n_min;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_res      = r_out;

endmodule

// ===== hdl/pending_command_retry_table_top.sv =====
// ---------------------------------------------------------------------------
// pending_command_retry_table_top
// table of outstanding commands with register, ack, clear and timeout tick
// ---------------------------------------------------------------------------
// Each request walks the command table one slot per cycle through a single
// table read port and one compare unit, while the result stream is not held
// by a deasserted i_m_tready, and takes no new request until done. Register
// scans the table then writes the chosen slot; state report clear makes a
// counting pass, then a freeing pass. Up to eight results come out per
// request, the final one flagged by o_m_tlast. Registers: timeout_ms at
// 0x0, max_retries at 0x4.
module pending_command_retry_table_top #(
    parameter int SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // device_id, channel, sequence_req, packet_tag, now_ms, reachable_mask
    input  logic [111:0]                i_s_tdata,
    // operation
    input  logic [1:0]                  i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // slot, out_device_id, out_sequence, out_packet_tag, freed_count, pad
    output logic [71:0]                 o_m_tdata,
    // kind
    output logic [2:0]                  o_m_tuser,
    output logic                        o_m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcrt_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pcrt_pkg::*;

    t_cfg w_cfg;
    t_res w_res;

    pcrt_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    pcrt_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (w_res)
    );

    assign o_m_tdata = {1'b0, w_res.freed, w_res.tag, w_res.sequence_no,
                        w_res.device, w_res.slot};
    assign o_m_tuser = w_res.kind;
    assign o_m_tlast = w_res.last;
    assign pready    = 1'b1;

endmodule

// ===== hdl/pcrt_checker.sv =====
// ---------------------------------------------------------------------------
// pcrt_checker
// port level assertions for the pending command retry table
// ---------------------------------------------------------------------------
`include "pending_command_retry_table_top_defines.svh"

module pcrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);
    import pcrt_pkg::*;

    logic w_out_none;
    logic w_out_reg;
    logic w_out_count;

    assign w_out_none  = o_m_tvalid && (o_m_tuser == KIND_NONE);
    assign w_out_reg   = o_m_tvalid && ((o_m_tuser == KIND_REG) ||
                                        (o_m_tuser == KIND_EVICT));
    assign w_out_count = o_m_tvalid && (o_m_tdata[70:67] != 4'd0);

    `PCRT_ASSERT_HOLD(ap_out_hold, i_clk, i_rst_n, o_m_tvalid, i_m_tready, o_m_tdata)

    // a request keeps the table busy for at least the following cycle
    `PCRT_ASSERT(ap_busy_after_req, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready)

    `PCRT_ASSERT(ap_none_is_last, i_clk, i_rst_n, w_out_none |-> o_m_tlast)

    `PCRT_ASSERT(ap_reg_single, i_clk, i_rst_n, w_out_reg |-> o_m_tlast)

    `PCRT_ASSERT(ap_count_only_freed, i_clk, i_rst_n, w_out_count |-> (o_m_tuser == KIND_FREED))

endmodule

bind pending_command_retry_table_top pcrt_checker u_pcrt_checker (.*);
